FILE: rtl/nsc_pkg.sv
package nsc_pkg;

    // Field widths fixed by the sentence format
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int NAME_LEN = 6;
    localparam int KINDS    = 5;

    // Special characters
    localparam logic [BYTE_W-1:0] CHAR_STAR = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;

    // Sentence kind codes on the result channel
    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_GGA   = 3'd1,
        KIND_GSA   = 3'd2,
        KIND_GSV   = 3'd3,
        KIND_RMC   = 3'd4,
        KIND_VTG   = 3'd5
    } t_kind;

    // Sentence names, first character in the top byte
    localparam logic [NAME_LEN*BYTE_W-1:0] KIND_NAMES [KINDS] = '{
        "$GNGGA", "$GNGSA", "$GPGSV", "$GNRMC", "$GNVTG"
    };

    // What the line tracker reports for the byte it just took
    typedef struct packed {
        logic             is_lf;
        logic             ok;
        t_kind            kind;
        logic [LEN_W-1:0] len;
    } t_line_result;

endpackage

FILE: rtl/nmea_sentence_checksum_classifier.sv
// Channel   Direction  Handshake                 Payload
// in        request    i_in_valid / o_in_stall   i_rx_byte
// out       result     o_out_valid / i_out_stall o_checksum_ok, o_sentence_kind,
//                                                o_line_length
//
// One byte is taken every cycle unless a line feed stalls the input; the input
// register and the line tracker feed a result register, so o_out_valid rises
// at the edge on which the line feed leaves the input register. Only a line
// feed that finds the result register full and stalled holds the input;
// other bytes keep flowing. Reset clears the line state and both valid flags.
module nmea_sentence_checksum_classifier
    import nsc_pkg::*;
#(
    parameter int MAX_LINE = 120
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_checksum_ok,
    output logic [2:0]        o_sentence_kind,
    output logic [LEN_W-1:0]  o_line_length
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic              r_ok;
    t_kind             r_kind;
    logic [LEN_W-1:0]  r_len;

    t_line_result      res;
    logic              out_free;
    logic              step;
    logic              accept;

    nsc_line_core #(
        .MAX_LINE (MAX_LINE)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // Handshake: a line feed waits for room in the result register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && (!res.is_lf || out_free);
    assign o_in_stall = r_in_valid && !step;
    assign accept     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res.is_lf) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.is_lf) begin
            r_ok   <= res.ok;
            r_kind <= res.kind;
            r_len  <= res.len;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_checksum_ok   = r_ok;
    assign o_sentence_kind = r_kind;
    assign o_line_length   = r_len;

endmodule

FILE: rtl/nsc_line_core.sv
module nsc_line_core
    import nsc_pkg::*;
#(
    parameter int MAX_LINE = 120
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output t_line_result      o_res
);

    logic [LEN_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic              r_par, n_par;
    logic [BYTE_W-1:0] r_recent [4];
    logic [BYTE_W-1:0] n_recent [4];
    logic [KINDS-1:0]  r_prefix, n_prefix;

    logic [KINDS-1:0]  prefix_upd;
    logic [BYTE_W-1:0] span_xor;
    logic              span_par;
    logic [BYTE_W-1:0] want;
    logic [LEN_W-1:0]  len;
    logic              is_lf;
    logic              ok;
    t_kind             kind;

    // Hex digit value; anything outside 0-9 and A-F counts as zero
    function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - "0");
        end else if (c >= "A" && c <= "F") begin
            v = 4'(c - "A" + 8'd10);
        end
        return v;
    endfunction

    assign is_lf = (i_byte == CHAR_LF);
    assign len   = r_count + LEN_W'(1);

    // Drop name candidates that disagree with this byte
    always_comb begin
        prefix_upd = r_prefix;
        if (r_count < LEN_W'(NAME_LEN)) begin
            for (int k = 0; k < KINDS; k++) begin
                if (i_byte != KIND_NAMES[k][BYTE_W*(NAME_LEN-1-int'(r_count[2:0])) +: BYTE_W])
                    prefix_upd[k] = 1'b0;
            end
        end
    end

    // Checksum over the span before the star
    always_comb begin
        span_xor = r_xor;
        span_par = r_par;
        for (int k = 0; k < 4; k++) begin
            span_xor = span_xor ^ r_recent[k];
            span_par = span_par ^ r_recent[k][BYTE_W-1];
        end
        want = {hex_value(r_recent[1]), hex_value(r_recent[2])};
        ok   = (r_count >= LEN_W'(NAME_LEN - 1)) && (r_recent[0] == CHAR_STAR)
               && !span_par && (span_xor == want);
    end

    // First surviving candidate names the sentence
    always_comb begin
        kind = KIND_OTHER;
        if (ok) begin
            for (int k = KINDS - 1; k >= 0; k--) begin
                if (prefix_upd[k])
                    kind = t_kind'(k + 1);
            end
        end
    end

    assign o_res = '{is_lf: is_lf, ok: ok, kind: kind, len: len};

    // Next line state
    always_comb begin
        n_count  = r_count;
        n_xor    = r_xor;
        n_par    = r_par;
        n_recent = r_recent;
        n_prefix = r_prefix;
        if (i_step) begin
            if (is_lf || len >= LEN_W'(MAX_LINE)) begin
                n_count  = '0;
                n_xor    = '0;
                n_par    = 1'b0;
                n_recent = '{default: '0};
                n_prefix = '1;
            end else begin
                n_count  = len;
                n_prefix = prefix_upd;
                if (r_count != '0) begin
                    n_xor = r_xor ^ i_byte;
                    n_par = r_par ^ i_byte[BYTE_W-1];
                end
                n_recent[0] = r_recent[1];
                n_recent[1] = r_recent[2];
                n_recent[2] = r_recent[3];
                n_recent[3] = i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_xor    <= '0;
            r_par    <= 1'b0;
            r_recent <= '{default: '0};
            r_prefix <= '1;
        end else begin
            r_count  <= n_count;
            r_xor    <= n_xor;
            r_par    <= n_par;
            r_recent <= n_recent;
            r_prefix <= n_prefix;
        end
    end

endmodule
